// ----- hw/rtl/ess_pkg.sv -----
// ----------------------------------------------------------------------------
// ess_pkg
// Shared widths, timings, codes and divider request/response types for the
// engine start/stop sequencer.
// ----------------------------------------------------------------------------
package ess_pkg;

    localparam int TIME_BITS   = 32;
    localparam int AVG_SAMPLES = 20;
    localparam int SLOT_W      = $clog2(AVG_SAMPLES + 1);
    localparam int RPM_W       = 12;
    localparam int SUM_W       = RPM_W + $clog2(AVG_SAMPLES + 1);
    localparam int DVSR_W      = 13;

    typedef logic [TIME_BITS-1:0] time_t;

    localparam time_t CALL_CONFIRM  = TIME_BITS'(1000);
    localparam time_t FULL_CONFIRM  = TIME_BITS'(3000);
    localparam time_t PRECRANK_MS   = TIME_BITS'(1000);
    localparam time_t CRANK_TIMEOUT = TIME_BITS'(5000);
    localparam time_t SEQ_TIMEOUT   = TIME_BITS'(60000);
    localparam time_t MASTER_OFF_MS = TIME_BITS'(6000);
    localparam time_t STALE_MS      = TIME_BITS'(1500);
    localparam time_t RUN_CONFIRM   = TIME_BITS'(750);
    localparam time_t START_HOLD    = TIME_BITS'(1000);
    localparam time_t LOST_CONFIRM  = TIME_BITS'(3000);
    localparam time_t SAMPLE_MS     = TIME_BITS'(500);
    localparam logic [RPM_W-1:0] CRANK_RPM = RPM_W'(100);
    localparam logic [RPM_W-1:0] RPM_MAX   = RPM_W'(4095);

    localparam logic [DVSR_W-1:0] BLINK_SLOT  = DVSR_W'(500);
    localparam logic [DVSR_W-1:0] BLINK_PAUSE = DVSR_W'(1500);

    localparam logic [3:0] SEQ_WAIT     = 4'd0;
    localparam logic [3:0] SEQ_MDELAY   = 4'd1;
    localparam logic [3:0] SEQ_PRECRANK = 4'd2;
    localparam logic [3:0] SEQ_STARTING = 4'd3;
    localparam logic [3:0] SEQ_UNLRUN   = 4'd4;
    localparam logic [3:0] SEQ_LOADED   = 4'd5;
    localparam logic [3:0] SEQ_STOPUNL  = 4'd6;
    localparam logic [3:0] SEQ_STOPPING = 4'd7;
    localparam logic [3:0] SEQ_FAULT    = 4'd8;

    localparam logic [2:0] FLT_NONE      = 3'd0;
    localparam logic [2:0] FLT_STARTFAIL = 3'd2;
    localparam logic [2:0] FLT_LOST      = 3'd4;
    localparam logic [2:0] FLT_OVERSPEED = 3'd5;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_PRESSURE = 3'd1;
    localparam logic [2:0] CAUSE_FAULT    = 3'd3;
    localparam logic [2:0] CAUSE_AUTO     = 3'd4;

    localparam logic [2:0] CFG_START_PULSE  = 3'd0;
    localparam logic [2:0] CFG_MASTER_DELAY = 3'd1;
    localparam logic [2:0] CFG_STOP_UNLOAD  = 3'd2;
    localparam logic [2:0] CFG_RUN_UNLOADED = 3'd3;
    localparam logic [2:0] CFG_START_RPM    = 3'd4;
    localparam logic [2:0] CFG_RUNNING_RPM  = 3'd5;
    localparam logic [2:0] CFG_OVERSPEED    = 3'd6;
    localparam logic [2:0] CFG_MAX_RPM      = 3'd7;

    typedef struct packed {
        logic                start;
        logic [TIME_BITS-1:0] dividend;
        logic [DVSR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [TIME_BITS-1:0] quotient;
        logic [DVSR_W-1:0]   remainder;
    } div_rsp_t;

endpackage

// ----- hw/rtl/engine_start_stop_sequencer.sv -----
// ----------------------------------------------------------------------------
// engine_start_stop_sequencer
// Millisecond-tick start/stop sequencer for an engine-driven compressor.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick and gives one output word. A tick
// that takes no rpm sample and has no fault code runs the front, sequencer
// step and output states; a sample tick adds the window sum (one stored
// sample per cycle, up to 20) and the average divide, and a tick with a fault
// adds the blink-phase divide. Both divides run on one bit-serial divider. A
// tick also holds in its output state while the previous output word waits
// for out_ready. The block takes no word while a tick is in work; it may take
// one while a finished word waits.
module engine_start_stop_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        pressure_call,
    input  logic        auto_switch,
    input  logic        reset_button,
    input  logic        force_unload,
    input  logic        rpm_frame_valid,
    input  logic [15:0] rpm_value,
    input  logic        remote_cmd_valid,
    input  logic        remote_cmd_permit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        master_drive,
    output logic        start_stop_drive,
    output logic        unloader_drive,
    output logic        idle_drive,
    output logic        kill_drive,
    output logic        fault_lamp,
    output logic [3:0]  sequencer_state,
    output logic [2:0]  fault_kind,
    output logic [2:0]  stop_cause,
    output logic [11:0] average_rpm,
    output logic        engine_running,
    output logic        auto_permitted
);
    import ess_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FRONT, ST_SUM, ST_AVG_GO, ST_AVG_WAIT,
        ST_SEQ, ST_LAMP_GO, ST_LAMP_WAIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic  armed;
        time_t start;
        logic  hit;
    } hold_t;

    localparam int T_CALL = 0;
    localparam int T_FULL = 1;
    localparam int T_RUN  = 2;
    localparam int T_LOST = 3;
    localparam int T_CONF = 4;

    function automatic hold_t hold_f(input logic armed, input time_t start,
                                     input logic cond, input time_t now,
                                     input time_t len);
        hold_t r;
        r.armed = armed;
        r.start = start;
        r.hit   = 1'b0;
        if (!cond)
            r.armed = 1'b0;
        else
        begin
            if (!armed)
            begin
                r.armed = 1'b1;
                r.start = now;
            end
            r.hit = (now - r.start) >= len;
        end
        return r;
    endfunction

    state_t state_reg;

    // configuration
    logic [13:0] start_pulse_reg;
    logic [15:0] master_delay_reg, stop_unload_reg, run_unloaded_reg, max_rpm_reg;
    logic [11:0] start_rpm_reg, running_rpm_reg, overspeed_reg;

    // latched tick inputs
    logic        call_reg, autosw_reg, rstbtn_reg, force_reg, fvalid_reg;
    logic [15:0] rv_reg;
    logic        rcv_reg, rcp_reg;

    // sequencer state
    time_t       ms_time_reg, entry_reg, run_start_reg, pend_reg, pstart_reg;
    time_t       lft_reg, lst_reg;
    time_t       tst_reg [5];
    logic [4:0]  armed_reg;
    logic [3:0]  seq_reg;
    logic [2:0]  fault_reg, cause_reg;
    logic        pact_reg, kill_reg, seen_reg, last_auto_reg, permit_reg;
    logic        conf_call_reg, conf_full_reg, conf_run_reg, conf_crank_reg;
    logic [RPM_W-1:0] cur_reg, avg_reg;
    logic [RPM_W-1:0] samples [AVG_SAMPLES];
    logic [SLOT_W-1:0] slot_reg, fill_reg, idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic        lamp_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ess_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- front of tick ----------------
    logic        f_permit, f_pact, f_present, f_due, f_seen;
    time_t       f_pend, f_lft;
    logic [RPM_W-1:0] f_cur;
    hold_t       h_run, h_call, h_full;

    always_comb
    begin
        f_permit = rcv_reg ? rcp_reg : permit_reg;
        f_pact   = pact_reg;
        f_pend   = pend_reg;
        if (pact_reg && ((ms_time_reg - pstart_reg) >= TIME_BITS'(start_pulse_reg)))
        begin
            f_pact = 1'b0;
            f_pend = ms_time_reg;
        end
        f_cur = cur_reg;
        f_lft = lft_reg;
        if (fvalid_reg && (rv_reg <= max_rpm_reg))
        begin
            f_cur = (rv_reg > 16'(RPM_MAX)) ? RPM_MAX : rv_reg[RPM_W-1:0];
            f_lft = ms_time_reg;
        end
        if ((ms_time_reg - f_lft) > STALE_MS)
            f_cur = '0;
        f_present = (f_cur >= running_rpm_reg) && ((ms_time_reg - f_lft) <= STALE_MS);
        h_run = hold_f(armed_reg[T_RUN], tst_reg[T_RUN], f_present, ms_time_reg,
                       RUN_CONFIRM);
        f_seen = 1'b1;
        if (seen_reg && autosw_reg && !last_auto_reg && !f_permit)
            f_permit = 1'b1;
        h_call = hold_f(armed_reg[T_CALL], tst_reg[T_CALL], call_reg, ms_time_reg,
                        CALL_CONFIRM);
        h_full = hold_f(armed_reg[T_FULL], tst_reg[T_FULL], !call_reg, ms_time_reg,
                        FULL_CONFIRM);
        f_due = (ms_time_reg - lst_reg) >= SAMPLE_MS;
    end

    // ---------------- sequencer step ----------------
    logic [3:0]  s_seq;
    logic [2:0]  s_fault, s_cause;
    logic        s_kill, s_pact, s_crank, s_arm_lost, s_arm_conf;
    time_t       s_entry, s_run_start, s_pstart, s_t_lost, s_t_conf;
    hold_t       h_lost, h_conf;
    logic        s_eff, s_fresh;

    always_comb
    begin
        s_seq       = seq_reg;
        s_fault     = fault_reg;
        s_cause     = cause_reg;
        s_kill      = kill_reg;
        s_pact      = pact_reg;
        s_crank     = conf_crank_reg;
        s_arm_lost  = armed_reg[T_LOST];
        s_arm_conf  = armed_reg[T_CONF];
        s_entry     = entry_reg;
        s_run_start = run_start_reg;
        s_pstart    = pstart_reg;
        s_t_lost    = tst_reg[T_LOST];
        s_t_conf    = tst_reg[T_CONF];
        s_eff       = autosw_reg && permit_reg;
        s_fresh     = (ms_time_reg - lft_reg) <= STALE_MS;
        h_lost      = '0;
        h_conf      = '0;
        if (rstbtn_reg)
        begin
            s_fault = FLT_NONE;
            s_kill  = 1'b0;
            s_cause = CAUSE_NONE;
            if (seq_reg == SEQ_FAULT)
            begin
                s_seq   = SEQ_WAIT;
                s_entry = ms_time_reg;
            end
        end
        if (!s_eff)
        begin
            s_cause    = CAUSE_AUTO;
            s_pact     = 1'b0;
            s_crank    = 1'b0;
            s_arm_conf = 1'b0;
            if (s_seq != SEQ_FAULT)
            begin
                s_seq   = SEQ_WAIT;
                s_entry = ms_time_reg;
            end
        end
        else
        begin
            h_lost = hold_f(s_arm_lost, s_t_lost,
                            ((s_seq == SEQ_UNLRUN) || (s_seq == SEQ_LOADED)) && !conf_run_reg,
                            ms_time_reg, LOST_CONFIRM);
            s_arm_lost = h_lost.armed;
            s_t_lost   = h_lost.start;
            if (h_lost.hit)
            begin
                s_fault = FLT_LOST;
                s_cause = CAUSE_FAULT;
                s_seq   = SEQ_FAULT;
                s_entry = ms_time_reg;
            end
            else
            begin
                unique case (s_seq)
                    SEQ_WAIT:
                    begin
                        s_cause    = CAUSE_NONE;
                        s_crank    = 1'b0;
                        s_arm_conf = 1'b0;
                        if (conf_run_reg)
                        begin
                            s_run_start = ms_time_reg;
                            s_seq       = SEQ_UNLRUN;
                            s_entry     = ms_time_reg;
                        end
                        else if (conf_call_reg && !force_reg)
                        begin
                            s_seq   = SEQ_MDELAY;
                            s_entry = ms_time_reg;
                        end
                    end
                    SEQ_MDELAY:
                    begin
                        if (conf_run_reg)
                        begin
                            s_run_start = ms_time_reg;
                            s_seq       = SEQ_UNLRUN;
                            s_entry     = ms_time_reg;
                        end
                        else if ((ms_time_reg - s_entry) >= TIME_BITS'(master_delay_reg))
                        begin
                            s_seq   = SEQ_PRECRANK;
                            s_entry = ms_time_reg;
                        end
                    end
                    SEQ_PRECRANK:
                    begin
                        if (conf_run_reg)
                        begin
                            s_run_start = ms_time_reg;
                            s_seq       = SEQ_UNLRUN;
                            s_entry     = ms_time_reg;
                        end
                        else if ((ms_time_reg - s_entry) >= PRECRANK_MS)
                        begin
                            s_crank    = 1'b0;
                            s_arm_conf = 1'b0;
                            s_pact     = 1'b1;
                            s_pstart   = ms_time_reg;
                            s_seq      = SEQ_STARTING;
                            s_entry    = ms_time_reg;
                        end
                    end
                    SEQ_STARTING:
                    begin
                        if (s_fresh && (cur_reg >= CRANK_RPM))
                            s_crank = 1'b1;
                        h_conf = hold_f(s_arm_conf, s_t_conf,
                                        s_fresh && (cur_reg >= start_rpm_reg),
                                        ms_time_reg, START_HOLD);
                        s_arm_conf = h_conf.armed;
                        s_t_conf   = h_conf.start;
                        if (h_conf.hit)
                        begin
                            s_run_start = ms_time_reg;
                            s_seq       = SEQ_UNLRUN;
                            s_entry     = ms_time_reg;
                        end
                        else if ((!s_crank && ((ms_time_reg - s_entry) >= CRANK_TIMEOUT))
                              || (s_crank && ((ms_time_reg - s_entry) >= SEQ_TIMEOUT)))
                        begin
                            s_fault = FLT_STARTFAIL;
                            s_cause = CAUSE_FAULT;
                            s_seq   = SEQ_FAULT;
                            s_entry = ms_time_reg;
                        end
                    end
                    SEQ_UNLRUN:
                    begin
                        if ((ms_time_reg - s_run_start) >= TIME_BITS'(run_unloaded_reg))
                        begin
                            s_seq   = SEQ_LOADED;
                            s_entry = ms_time_reg;
                        end
                    end
                    SEQ_LOADED:
                    begin
                        if (conf_full_reg)
                        begin
                            s_cause = CAUSE_PRESSURE;
                            s_seq   = SEQ_STOPUNL;
                            s_entry = ms_time_reg;
                        end
                    end
                    SEQ_STOPUNL:
                    begin
                        if (!conf_run_reg)
                        begin
                            s_seq   = SEQ_WAIT;
                            s_entry = ms_time_reg;
                        end
                        else if ((ms_time_reg - s_entry) >= TIME_BITS'(stop_unload_reg))
                        begin
                            s_pact   = 1'b1;
                            s_pstart = ms_time_reg;
                            s_seq    = SEQ_STOPPING;
                            s_entry  = ms_time_reg;
                        end
                    end
                    SEQ_STOPPING:
                    begin
                        if (!s_pact && ((ms_time_reg - pend_reg) >= MASTER_OFF_MS))
                        begin
                            s_seq   = SEQ_WAIT;
                            s_entry = ms_time_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------- divider requests and lamp phase ----------------
    logic [DVSR_W-1:0] blink_on;
    logic [DVSR_W+14:0] phase_prod;
    logic              avg_trip;

    always_comb
    begin
        blink_on = DVSR_W'({10'd0, fault_reg} * BLINK_SLOT);
        div_req.start    = (state_reg == ST_AVG_GO) || (state_reg == ST_LAMP_GO);
        div_req.dividend = (state_reg == ST_AVG_GO) ? TIME_BITS'(sum_reg) : ms_time_reg;
        div_req.divisor  = (state_reg == ST_AVG_GO) ? DVSR_W'(fill_reg)
                                                    : DVSR_W'(blink_on + BLINK_PAUSE);
        // floor(t / 250) by reciprocal, exact for the remainders seen here
        phase_prod = (DVSR_W+15)'(div_rsp.remainder) * (DVSR_W+15)'(16778);
        avg_trip   = (fill_reg >= SLOT_W'(AVG_SAMPLES))
                  && (div_rsp.quotient[RPM_W-1:0] >= overspeed_reg)
                  && (fault_reg != FLT_OVERSPEED);
    end

    // ---------------- output word ----------------
    logic o_eff, o_master, o_unload, o_idle, o_kill;

    always_comb
    begin
        o_eff    = autosw_reg && permit_reg;
        o_master = 1'b0;
        o_unload = force_reg;
        o_idle   = 1'b0;
        o_kill   = 1'b0;
        if (o_eff)
        begin
            unique case (seq_reg)
                SEQ_MDELAY:
                    o_master = 1'b1;
                SEQ_PRECRANK, SEQ_STARTING, SEQ_UNLRUN:
                begin
                    o_master = 1'b1;
                    o_unload = 1'b1;
                end
                SEQ_LOADED:
                begin
                    o_master = 1'b1;
                    o_idle   = force_reg;
                end
                SEQ_STOPUNL, SEQ_STOPPING:
                begin
                    o_master = 1'b1;
                    o_unload = 1'b1;
                    o_idle   = 1'b1;
                end
                SEQ_FAULT:
                begin
                    o_master = conf_run_reg && !kill_reg;
                    o_unload = conf_run_reg || force_reg;
                end
                default:
                begin
                end
            endcase
            if (kill_reg)
            begin
                o_kill   = 1'b1;
                o_unload = 1'b1;
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pulse_reg  <= 14'd1250;
            master_delay_reg <= 16'd4000;
            stop_unload_reg  <= 16'd10000;
            run_unloaded_reg <= 16'd15000;
            start_rpm_reg    <= 12'd800;
            running_rpm_reg  <= 12'd400;
            overspeed_reg    <= 12'd3500;
            max_rpm_reg      <= 16'd4000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_PULSE:  start_pulse_reg  <= cfg_data[13:0];
                CFG_MASTER_DELAY: master_delay_reg <= cfg_data;
                CFG_STOP_UNLOAD:  stop_unload_reg  <= cfg_data;
                CFG_RUN_UNLOADED: run_unloaded_reg <= cfg_data;
                CFG_START_RPM:    start_rpm_reg    <= cfg_data[11:0];
                CFG_RUNNING_RPM:  running_rpm_reg  <= cfg_data[11:0];
                CFG_OVERSPEED:    overspeed_reg    <= cfg_data[11:0];
                CFG_MAX_RPM:      max_rpm_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sample window; every slot below the fill count has been written
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FRONT) && f_due)
            samples[slot_reg] <= f_present ? f_cur : '0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            call_reg   <= pressure_call;
            autosw_reg <= auto_switch;
            rstbtn_reg <= reset_button;
            force_reg  <= force_unload;
            fvalid_reg <= rpm_frame_valid;
            rv_reg     <= rpm_value;
            rcv_reg    <= remote_cmd_valid;
            rcp_reg    <= remote_cmd_permit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ms_time_reg    <= '0;
            entry_reg      <= '0;
            run_start_reg  <= '0;
            pend_reg       <= '0;
            pstart_reg     <= '0;
            lft_reg        <= '0;
            lst_reg        <= '0;
            for (int i = 0; i < 5; i++)
                tst_reg[i] <= '0;
            armed_reg      <= '0;
            seq_reg        <= SEQ_WAIT;
            fault_reg      <= FLT_NONE;
            cause_reg      <= CAUSE_NONE;
            pact_reg       <= 1'b0;
            kill_reg       <= 1'b0;
            seen_reg       <= 1'b0;
            last_auto_reg  <= 1'b0;
            permit_reg     <= 1'b1;
            conf_call_reg  <= 1'b0;
            conf_full_reg  <= 1'b0;
            conf_run_reg   <= 1'b0;
            conf_crank_reg <= 1'b0;
            cur_reg        <= '0;
            avg_reg        <= '0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            lamp_reg       <= 1'b0;
            out_valid      <= 1'b0;
            master_drive     <= 1'b0;
            start_stop_drive <= 1'b0;
            unloader_drive   <= 1'b0;
            idle_drive       <= 1'b0;
            kill_drive       <= 1'b0;
            fault_lamp       <= 1'b0;
            sequencer_state  <= SEQ_WAIT;
            fault_kind       <= FLT_NONE;
            stop_cause       <= CAUSE_NONE;
            average_rpm      <= '0;
            engine_running   <= 1'b0;
            auto_permitted   <= 1'b1;
        end
        else
        begin
            // the output state reloads the word itself
            if (out_valid && out_ready && (state_reg != ST_OUT))
                out_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_FRONT;
                end
                ST_FRONT:
                begin
                    permit_reg       <= f_permit;
                    pact_reg         <= f_pact;
                    pend_reg         <= f_pend;
                    cur_reg          <= f_cur;
                    lft_reg          <= f_lft;
                    armed_reg[T_RUN] <= h_run.armed;
                    tst_reg[T_RUN]   <= h_run.start;
                    conf_run_reg     <= h_run.hit;
                    seen_reg         <= f_seen;
                    last_auto_reg    <= autosw_reg;
                    armed_reg[T_CALL] <= h_call.armed;
                    tst_reg[T_CALL]  <= h_call.start;
                    conf_call_reg    <= h_call.hit;
                    armed_reg[T_FULL] <= h_full.armed;
                    tst_reg[T_FULL]  <= h_full.start;
                    conf_full_reg    <= h_full.hit;
                    if (f_due)
                    begin
                        lst_reg  <= ms_time_reg;
                        slot_reg <= (slot_reg == SLOT_W'(AVG_SAMPLES - 1))
                                    ? '0 : slot_reg + 1'b1;
                        if (fill_reg < SLOT_W'(AVG_SAMPLES))
                            fill_reg <= fill_reg + 1'b1;
                        sum_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                    else
                        state_reg <= ST_SEQ;
                end
                ST_SUM:
                begin
                    // accumulate one stored sample per cycle
                    sum_reg <= sum_reg + SUM_W'(samples[idx_reg]);
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == fill_reg - 1'b1)
                        state_reg <= ST_AVG_GO;
                end
                ST_AVG_GO:
                    state_reg <= ST_AVG_WAIT;
                ST_AVG_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg <= div_rsp.quotient[RPM_W-1:0];
                        if (avg_trip)
                        begin
                            fault_reg <= FLT_OVERSPEED;
                            cause_reg <= CAUSE_FAULT;
                            kill_reg  <= 1'b1;
                            seq_reg   <= SEQ_FAULT;
                            entry_reg <= ms_time_reg;
                        end
                        state_reg <= ST_SEQ;
                    end
                end
                ST_SEQ:
                begin
                    seq_reg           <= s_seq;
                    fault_reg         <= s_fault;
                    cause_reg         <= s_cause;
                    kill_reg          <= s_kill;
                    pact_reg          <= s_pact;
                    conf_crank_reg    <= s_crank;
                    armed_reg[T_LOST] <= s_arm_lost;
                    armed_reg[T_CONF] <= s_arm_conf;
                    tst_reg[T_LOST]   <= s_t_lost;
                    tst_reg[T_CONF]   <= s_t_conf;
                    entry_reg         <= s_entry;
                    run_start_reg     <= s_run_start;
                    pstart_reg        <= s_pstart;
                    lamp_reg          <= 1'b0;
                    state_reg <= (s_fault == FLT_NONE) ? ST_OUT : ST_LAMP_GO;
                end
                ST_LAMP_GO:
                    state_reg <= ST_LAMP_WAIT;
                ST_LAMP_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        lamp_reg  <= (div_rsp.remainder < blink_on) && !phase_prod[22];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hold until the previous word has left
                    if (!out_valid || out_ready)
                    begin
                        out_valid        <= 1'b1;
                        master_drive     <= o_master;
                        start_stop_drive <= o_eff && pact_reg;
                        unloader_drive   <= o_unload;
                        idle_drive       <= o_idle;
                        kill_drive       <= o_kill;
                        fault_lamp       <= lamp_reg;
                        sequencer_state  <= seq_reg;
                        fault_kind       <= fault_reg;
                        stop_cause       <= cause_reg;
                        average_rpm      <= avg_reg;
                        engine_running   <= conf_run_reg;
                        auto_permitted   <= permit_reg;
                        ms_time_reg      <= ms_time_reg + 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_FRONT)
        else $error("accepted word did not start a tick");
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_AVG_WAIT) || (state_reg == ST_LAMP_WAIT))
        else $error("divider finished outside a wait state");
    a_seq_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEQ |=> (state_reg == ST_OUT) || (state_reg == ST_LAMP_GO))
        else $error("sequencer step went astray");
    a_kill_unload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kill_drive |-> unloader_drive)
        else $error("kill driven without unloader");
`endif

endmodule

// ----- hw/rtl/ess_div.sv -----
// ----------------------------------------------------------------------------
// ess_div
// Restoring divider, one quotient bit per clock, shared by the rpm average
// and the fault lamp blink phase.
// ----------------------------------------------------------------------------
module ess_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ess_pkg::div_req_t req,
    output ess_pkg::div_rsp_t rsp
);
    import ess_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] quo_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    divisor_reg;
    logic [DVSR_W:0]      rem_shift;
    logic [DVSR_W-1:0]    rem_next;
    logic                 qbit;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TIME_BITS-1]};
        if (rem_shift >= {1'b0, divisor_reg})
        begin
            rem_next = DVSR_W'(rem_shift - {1'b0, divisor_reg});
            qbit     = 1'b1;
        end
        else
        begin
            rem_next = rem_shift[DVSR_W-1:0];
            qbit     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                quo_reg     <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[TIME_BITS-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TIME_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
